FILE: design/sfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the serial-bus frame sync and channel extract
// block: item words, queue entry, command and register codes.
// ----------------------------------------------------------------------------
package sfs_pkg;

    // window geometry: the newest byte plus the 24 held in the shift line
    localparam int WIN_KEEP     = 24;
    localparam int FILL_W       = 5;
    localparam int PAYLOAD_W    = 44;
    localparam int CHAN_W       = 11;
    localparam int CHAN_SHIFT   = 4;
    localparam int OUT_CHAN_W   = 15;

    // queue between front and back
    localparam int QPTR_W       = 2;
    localparam int QUEUE_DEPTH  = 2 ** QPTR_W;
    localparam int QCNT_W       = QPTR_W + 1;

    // configuration port
    localparam int CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [7:0] START_MARKER_RST = 8'd15;
    localparam logic [7:0] END_MARKER_RST   = 8'd0;

    // command codes
    localparam logic [1:0] CMD_RX_BYTE  = 2'd0;
    localparam logic [1:0] CMD_UART_ERR = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    // sticky flag bit positions
    localparam int ERR_FRAMING = 0;
    localparam int ERR_PARITY  = 1;
    localparam int ERR_OVERRUN = 2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic       framing_fault;
        logic       parity_fault;
        logic       overrun_fault;
        logic [2:0] clear_mask;
    } t_in_item;

    typedef struct packed {
        logic                  frame_ready;
        logic [OUT_CHAN_W-1:0] chan_zero;
        logic [OUT_CHAN_W-1:0] chan_one;
        logic [OUT_CHAN_W-1:0] chan_two;
        logic [OUT_CHAN_W-1:0] chan_three;
        logic [2:0]            error_flags;
    } t_out_item;

    typedef struct packed {
        logic                 frame_ready;
        logic [PAYLOAD_W-1:0] payload;
        logic [2:0]           error_flags;
    } t_q_entry;

    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_push;

    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_head;

    typedef struct packed {
        logic       valid;
        logic [CFG_IDX_W-1:0] index;
        logic [7:0] data;
    } t_cfg_wr;

endpackage

FILE: design/sbus_frame_sync_channel_extract_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_sync_channel_extract_core
// Serial-bus frame synchronizer and channel extractor, top level.
// ----------------------------------------------------------------------------
// Takes one input word per clock while the input is not stalled and gives
// exactly one result word for each, in order. The front updates the byte
// window and flags in the cycle of acceptance and writes the entry into a
// four-entry queue, and the back then loads it into the output register once
// that register is empty or being taken. Input stall rises only when that
// queue is full; with the output free, the sustained rate is one word per
// cycle.
// The configuration port is always ready, and marker writes take effect at
// the next edge; write them only while no word is in flight.
module sbus_frame_sync_channel_extract_core import sfs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_q_push push;
    t_q_head head;
    t_cfg_wr cfg;
    logic    q_full;
    logic    pop;
    logic    accept;

    assign o_in_stall  = q_full;
    assign accept      = i_in_valid && !q_full;
    assign o_cfg_ready = 1'b1;

    // config write bundle
    always_comb begin
        cfg.valid = i_cfg_valid;
        cfg.index = i_cfg_index;
        cfg.data  = i_cfg_data;
    end

    sfs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_in_data),
        .i_cfg   (cfg),
        .o_push  (push)
    );

    sfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full)
    );

    sfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: design/sfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_front
// Accepts words, keeps the byte window, fill count, markers and sticky flags,
// detects frames and pushes one queue entry per accepted word.
// ----------------------------------------------------------------------------
module sfs_front import sfs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  t_cfg_wr  i_cfg,
    output t_q_push  o_push
);

    logic [7:0]        r_win [WIN_KEEP];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [2:0]        r_err;
    logic [2:0]        n_err;
    logic [7:0]        r_start;
    logic [7:0]        r_end;
    logic              full_win;
    logic              is_rx;
    logic              frame;
    logic [47:0]       data_bytes;

    assign is_rx    = (i_item.cmd == CMD_RX_BYTE);
    assign full_win = (r_fill == FILL_W'(WIN_KEEP));
    assign frame    = is_rx && full_win && (r_win[WIN_KEEP-1] == r_start)
                      && (i_item.rx_byte == r_end);

    // data bytes after the start byte, first one in the low bits
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            data_bytes[k*8 +: 8] = r_win[WIN_KEEP-2-k];
        end
    end

    // next fill count
    always_comb begin
        n_fill = r_fill;
        if (is_rx) begin
            if (frame) begin
                n_fill = FILL_W'(1);
            end else if (!full_win) begin
                n_fill = r_fill + FILL_W'(1);
            end
        end
    end

    // sticky flags, framing over parity over overrun
    always_comb begin
        n_err = r_err;
        case (i_item.cmd)
            CMD_UART_ERR: begin
                if (i_item.framing_fault) begin
                    n_err[ERR_FRAMING] = 1'b1;
                end else if (i_item.parity_fault) begin
                    n_err[ERR_PARITY] = 1'b1;
                end else if (i_item.overrun_fault) begin
                    n_err[ERR_OVERRUN] = 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_err = r_err & ~i_item.clear_mask;
            end
            default: begin
                n_err = r_err;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_err   <= '0;
            r_start <= START_MARKER_RST;
            r_end   <= END_MARKER_RST;
        end else begin
            if (i_accept) begin
                r_fill <= n_fill;
                r_err  <= n_err;
            end
            if (i_cfg.valid && i_cfg.index == CFG_START_MARKER) begin
                r_start <= i_cfg.data;
            end
            if (i_cfg.valid && i_cfg.index == CFG_END_MARKER) begin
                r_end <= i_cfg.data;
            end
        end
    end

    // byte shift line, newest at the low end
    always_ff @(posedge i_clk) begin
        if (i_accept && is_rx) begin
            r_win[0] <= i_item.rx_byte;
            for (int i = 1; i < WIN_KEEP; i++) begin
                r_win[i] <= r_win[i-1];
            end
        end
    end

    // queue entry
    always_comb begin
        o_push.valid             = i_accept;
        o_push.entry.frame_ready = frame;
        o_push.entry.payload     = data_bytes[PAYLOAD_W-1:0];
        o_push.entry.error_flags = n_err;
    end

    a_frame_restarts_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && frame) |=> (r_fill == FILL_W'(1)))
        else $error("fill count not restarted after a frame");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (r_fill <= FILL_W'(WIN_KEEP)))
        else $error("fill count beyond the window");

endmodule

FILE: design/sfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_queue
// Short first-in first-out queue of entries between the front and the back.
// ----------------------------------------------------------------------------
module sfs_queue import sfs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_push i_push,
    input  logic    i_pop,
    output t_q_head o_head,
    output logic    o_full
);

    t_q_entry          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rptr];
    assign do_pop       = i_pop && o_head.valid;

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push.valid && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push.valid && do_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.entry;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.valid)
        else $error("push into a full queue");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: design/sfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_back
// Takes queue entries, splits the payload bits into four channels and holds
// the result word in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module sfs_back import sfs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic      r_valid;
    t_out_item r_data;
    t_out_item n_data;
    logic      load;

    assign load  = i_head.valid && (!r_valid || !i_out_stall);
    assign o_pop = load;

    // channel split, 11 bits each, moved up by 4
    function automatic logic [OUT_CHAN_W-1:0] chan_of(
        input logic [PAYLOAD_W-1:0] bits,
        input int                   idx,
        input logic                 ready
    );
        logic [CHAN_W-1:0] raw;
        raw = bits[idx*CHAN_W +: CHAN_W];
        return ready ? {raw, {CHAN_SHIFT{1'b0}}} : '0;
    endfunction

    always_comb begin
        n_data.frame_ready = i_head.entry.frame_ready;
        n_data.chan_zero   = chan_of(i_head.entry.payload, 0, i_head.entry.frame_ready);
        n_data.chan_one    = chan_of(i_head.entry.payload, 1, i_head.entry.frame_ready);
        n_data.chan_two    = chan_of(i_head.entry.payload, 2, i_head.entry.frame_ready);
        n_data.chan_three  = chan_of(i_head.entry.payload, 3, i_head.entry.frame_ready);
        n_data.error_flags = i_head.entry.error_flags;
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    a_no_frame_zero_chans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_data.frame_ready) |-> (r_data.chan_zero == '0 &&
        r_data.chan_one == '0 && r_data.chan_two == '0 && r_data.chan_three == '0))
        else $error("channel data without a frame");

    a_chan_low_bits_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_data.chan_zero[CHAN_SHIFT-1:0] == '0 &&
        r_data.chan_three[CHAN_SHIFT-1:0] == '0))
        else $error("channel low bits not zero");

endmodule
